// File: hdl/phd_pkg.sv
`timescale 1ns / 1ps
package phd_pkg;

   localparam int HEIGHT_BITS = 12;
   localparam int TICK_BITS = 16;
   localparam int CSR_DATA_BITS = (HEIGHT_BITS > TICK_BITS) ? HEIGHT_BITS : TICK_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int REQ_DATA_BITS = ((HEIGHT_BITS + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [HEIGHT_BITS-1:0] RST_THRESHOLD = HEIGHT_BITS'(4096 - 2800);
   localparam logic [HEIGHT_BITS-1:0] RST_DEPTH = HEIGHT_BITS'(500);
   localparam logic [TICK_BITS-1:0] RST_ENTRY = TICK_BITS'(2000);
   localparam logic [TICK_BITS-1:0] RST_PASS_FAST = TICK_BITS'(600);
   localparam logic [TICK_BITS-1:0] RST_PASS_SLOW = TICK_BITS'(1000);
   localparam logic [TICK_BITS-1:0] RST_HOLE_FAST = TICK_BITS'(300);
   localparam logic [TICK_BITS-1:0] RST_HOLE_SLOW = TICK_BITS'(600);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PUCK_THRESHOLD = 3'd0,
      CSR_HOLE_DEPTH = 3'd1,
      CSR_ENTRY_TICKS = 3'd2,
      CSR_PASS_TICKS_FAST = 3'd3,
      CSR_PASS_TICKS_SLOW = 3'd4,
      CSR_HOLE_TICKS_FAST = 3'd5,
      CSR_HOLE_TICKS_SLOW = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ENTRY = 2'd1,
      PH_TRACK = 2'd2,
      PH_CLOSE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      OUT_COMPLETE = 2'd0,
      OUT_NO_ENTRY = 2'd1,
      OUT_NO_HOLE = 2'd2,
      OUT_NOT_CLOSED = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [HEIGHT_BITS-1:0] puck_threshold;
      logic [HEIGHT_BITS-1:0] hole_depth;
      logic [TICK_BITS-1:0] entry_ticks;
      logic [TICK_BITS-1:0] pass_ticks_fast;
      logic [TICK_BITS-1:0] pass_ticks_slow;
      logic [TICK_BITS-1:0] hole_ticks_fast;
      logic [TICK_BITS-1:0] hole_ticks_slow;
   } cfg_type;

   typedef struct packed {
      logic [1:0] op;
      logic [HEIGHT_BITS-1:0] height;
      logic slow_mode;
   } item_type;

   typedef struct packed {
      logic hole_found;
      outcome_type outcome;
   } res_type;

endpackage

// File: hdl/phd_csr.sv
`timescale 1ns / 1ps
module phd_csr (
   input logic clock,
   input logic reset,
   input logic csr_we,
   input logic [phd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [phd_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output phd_pkg::cfg_type cfg
);
   import phd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PUCK_THRESHOLD: cfg_in.puck_threshold = csr_wdata[HEIGHT_BITS-1:0];
            CSR_HOLE_DEPTH: cfg_in.hole_depth = csr_wdata[HEIGHT_BITS-1:0];
            CSR_ENTRY_TICKS: cfg_in.entry_ticks = csr_wdata[TICK_BITS-1:0];
            CSR_PASS_TICKS_FAST: cfg_in.pass_ticks_fast = csr_wdata[TICK_BITS-1:0];
            CSR_PASS_TICKS_SLOW: cfg_in.pass_ticks_slow = csr_wdata[TICK_BITS-1:0];
            CSR_HOLE_TICKS_FAST: cfg_in.hole_ticks_fast = csr_wdata[TICK_BITS-1:0];
            CSR_HOLE_TICKS_SLOW: cfg_in.hole_ticks_slow = csr_wdata[TICK_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.puck_threshold <= RST_THRESHOLD;
         cfg_ff.hole_depth <= RST_DEPTH;
         cfg_ff.entry_ticks <= RST_ENTRY;
         cfg_ff.pass_ticks_fast <= RST_PASS_FAST;
         cfg_ff.pass_ticks_slow <= RST_PASS_SLOW;
         cfg_ff.hole_ticks_fast <= RST_HOLE_FAST;
         cfg_ff.hole_ticks_slow <= RST_HOLE_SLOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/phd_detect.sv
`timescale 1ns / 1ps
module phd_detect (
   input logic clock,
   input logic reset,
   input phd_pkg::cfg_type cfg,
   input logic item_valid,
   input phd_pkg::item_type item,
   output logic res_valid,
   output phd_pkg::res_type res
);
   import phd_pkg::*;

   phase_type phase_ff, phase_in;
   logic [HEIGHT_BITS-1:0] peak_ff, peak_in;
   logic [TICK_BITS-1:0] ticks_ff, ticks_in;
   logic slow_ff, slow_in;

   logic [HEIGHT_BITS:0] reach;
   logic [HEIGHT_BITS:0] peak_ext;
   logic done;
   outcome_type outcome;

   always_comb begin
      reach = {1'b0, item.height} + {1'b0, cfg.hole_depth};
      peak_ext = {1'b0, peak_ff};
      phase_in = phase_ff;
      peak_in = peak_ff;
      ticks_in = ticks_ff;
      slow_in = slow_ff;
      done = 1'b0;
      outcome = OUT_COMPLETE;
      if (item_valid) begin
         if (op_type'(item.op) == OP_START) begin
            phase_in = PH_ENTRY;
            slow_in = item.slow_mode;
            peak_in = '0;
            ticks_in = cfg.entry_ticks;
         end else if (phase_ff != PH_IDLE) begin
            unique case (op_type'(item.op))
               OP_SAMPLE: begin
                  unique case (phase_ff)
                     PH_ENTRY: begin
                        if (item.height >= cfg.puck_threshold) begin
                           peak_in = item.height;
                           phase_in = PH_TRACK;
                           ticks_in = slow_ff ? cfg.pass_ticks_slow : cfg.pass_ticks_fast;
                        end
                     end
                     PH_TRACK: begin
                        if (reach > peak_ext) begin
                           if (item.height > peak_ff) peak_in = item.height;
                        end else if (reach < peak_ext) begin
                           phase_in = PH_CLOSE;
                           ticks_in = slow_ff ? cfg.hole_ticks_slow : cfg.hole_ticks_fast;
                        end else begin
                           done = 1'b1;
                           outcome = OUT_NO_HOLE;
                        end
                     end
                     PH_CLOSE: begin
                        if (item.height > cfg.puck_threshold) begin
                           done = 1'b1;
                           outcome = OUT_COMPLETE;
                        end else if (item.height == cfg.puck_threshold) begin
                           done = 1'b1;
                           outcome = OUT_NOT_CLOSED;
                        end
                     end
                     default: phase_in = phase_ff;
                  endcase
               end
               OP_TICK: begin
                  if (ticks_ff > TICK_BITS'(1)) begin
                     ticks_in = ticks_ff - TICK_BITS'(1);
                  end else begin
                     ticks_in = '0;
                     done = 1'b1;
                     unique case (phase_ff)
                        PH_ENTRY: outcome = OUT_NO_ENTRY;
                        PH_TRACK: outcome = OUT_NO_HOLE;
                        default: outcome = OUT_NOT_CLOSED;
                     endcase
                  end
               end
               default: done = 1'b0;
            endcase
            if (done) phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         peak_ff <= '0;
         ticks_ff <= '0;
         slow_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         peak_ff <= peak_in;
         ticks_ff <= ticks_in;
         slow_ff <= slow_in;
      end
   end

   assign res_valid = done;
   assign res.hole_found = (outcome == OUT_COMPLETE);
   assign res.outcome = outcome;

endmodule

// File: hdl/phd_out_buf.sv
`timescale 1ns / 1ps
module phd_out_buf (
   input logic clock,
   input logic reset,
   input logic res_valid,
   input phd_pkg::res_type res,
   output logic res_room,
   output logic out_valid,
   input logic out_ready,
   output phd_pkg::res_type out_res
);
   import phd_pkg::*;

   logic main_valid_ff, main_valid_in;
   logic skid_valid_ff, skid_valid_in;
   res_type main_ff, main_in;
   res_type skid_ff, skid_in;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in = main_ff;
      skid_in = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = res_valid;
            main_in = res;
         end
      end else if (res_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign res_room = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_res = main_ff;

endmodule

// File: hdl/puck_hole_detector.sv
`timescale 1ns / 1ps
// A transaction that ends detection passes through the input register and the output buffer.
// Throughput: one transaction per cycle while the output buffer has room; the state update is a compare and count.
// Output stage is a two-entry skid buffer, so req_tready depends on registers only.
// Reset (synchronous, active high) empties all stages, returns detection to idle
// and loads the configuration registers with their default values.
module puck_hole_detector (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [phd_pkg::REQ_DATA_BITS-1:0] req_tdata, // height, slow_mode, zero pad
   input logic [1:0] req_tuser, // op
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [phd_pkg::RSP_DATA_BITS-1:0] rsp_tdata, // hole_found, outcome, zero pad
   input logic csr_we,
   input logic [phd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [phd_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import phd_pkg::*;

   cfg_type cfg;
   logic in_valid_ff, in_valid_in;
   item_type item_ff, item_in;
   logic res_room;
   logic advance;
   logic res_valid;
   res_type res;
   logic out_valid;
   res_type out_res;

   assign advance = in_valid_ff && res_room;
   assign req_tready = !in_valid_ff || res_room;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in = item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         item_in.op = req_tuser;
         item_in.height = req_tdata[HEIGHT_BITS-1:0];
         item_in.slow_mode = req_tdata[HEIGHT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      item_ff <= item_in;
   end

   phd_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg(cfg)
   );

   phd_detect u_detect (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .item_valid(advance),
      .item(item_ff),
      .res_valid(res_valid),
      .res(res)
   );

   phd_out_buf u_out_buf (
      .clock(clock),
      .reset(reset),
      .res_valid(res_valid),
      .res(res),
      .res_room(res_room),
      .out_valid(out_valid),
      .out_ready(rsp_tready),
      .out_res(out_res)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata = {{(RSP_DATA_BITS - 3){1'b0}}, out_res.outcome, out_res.hole_found};

endmodule

// File: test/phd_outcome_check.sv
`timescale 1ns / 1ps
module phd_outcome_check (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [phd_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic [1:0] req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [phd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic csr_we,
   input logic [phd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [phd_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int fail_count,
   output int pending,
   output int results_seen,
   output int holes_seen
);
   import phd_pkg::*;

   cfg_type cfg;
   phase_type det_phase;
   logic [HEIGHT_BITS-1:0] det_peak;
   logic [TICK_BITS-1:0] det_ticks;
   logic det_slow;
   res_type outcome_q[$];
   int n_fail = 0;
   int n_results = 0;
   int n_holes = 0;

   task automatic end_detection(input outcome_type oc, output res_type res);
      res.hole_found = (oc == OUT_COMPLETE);
      res.outcome = oc;
      det_phase = PH_IDLE;
   endtask

   task automatic classify_step(input item_type it, output bit done, output res_type res);
      int lim;
      int s;
      done = 1'b0;
      res = '0;
      lim = int'(det_peak) - int'(cfg.hole_depth);
      s = int'(it.height);
      case (it.op)
         OP_START: begin
            det_phase = PH_ENTRY;
            det_slow = it.slow_mode;
            det_peak = '0;
            det_ticks = cfg.entry_ticks;
         end
         OP_SAMPLE: begin
            case (det_phase)
               PH_IDLE: ;
               PH_ENTRY: begin
                  if (it.height >= cfg.puck_threshold) begin
                     det_peak = it.height;
                     det_phase = PH_TRACK;
                     det_ticks = det_slow ? cfg.pass_ticks_slow : cfg.pass_ticks_fast;
                  end
               end
               PH_TRACK: begin
                  if (s > lim) begin
                     if (it.height > det_peak)
                        det_peak = it.height;
                  end else if (s < lim) begin
                     det_phase = PH_CLOSE;
                     det_ticks = det_slow ? cfg.hole_ticks_slow : cfg.hole_ticks_fast;
                  end else begin
                     end_detection(OUT_NO_HOLE, res);
                     done = 1'b1;
                  end
               end
               default: begin
                  if (it.height > cfg.puck_threshold) begin
                     end_detection(OUT_COMPLETE, res);
                     done = 1'b1;
                  end else if (it.height == cfg.puck_threshold) begin
                     end_detection(OUT_NOT_CLOSED, res);
                     done = 1'b1;
                  end
               end
            endcase
         end
         OP_TICK: begin
            if (det_phase != PH_IDLE) begin
               if (det_ticks > 1) begin
                  det_ticks = det_ticks - 1'b1;
               end else begin
                  det_ticks = '0;
                  done = 1'b1;
                  case (det_phase)
                     PH_ENTRY: end_detection(OUT_NO_ENTRY, res);
                     PH_TRACK: end_detection(OUT_NO_HOLE, res);
                     default: end_detection(OUT_NOT_CLOSED, res);
                  endcase
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      item_type it;
      bit done;
      res_type want;
      res_type got;
      if (reset) begin
         cfg.puck_threshold = RST_THRESHOLD;
         cfg.hole_depth = RST_DEPTH;
         cfg.entry_ticks = RST_ENTRY;
         cfg.pass_ticks_fast = RST_PASS_FAST;
         cfg.pass_ticks_slow = RST_PASS_SLOW;
         cfg.hole_ticks_fast = RST_HOLE_FAST;
         cfg.hole_ticks_slow = RST_HOLE_SLOW;
         det_phase = PH_IDLE;
         det_peak = '0;
         det_ticks = '0;
         det_slow = 1'b0;
         outcome_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_PUCK_THRESHOLD: cfg.puck_threshold = csr_wdata[HEIGHT_BITS-1:0];
               CSR_HOLE_DEPTH: cfg.hole_depth = csr_wdata[HEIGHT_BITS-1:0];
               CSR_ENTRY_TICKS: cfg.entry_ticks = csr_wdata[TICK_BITS-1:0];
               CSR_PASS_TICKS_FAST: cfg.pass_ticks_fast = csr_wdata[TICK_BITS-1:0];
               CSR_PASS_TICKS_SLOW: cfg.pass_ticks_slow = csr_wdata[TICK_BITS-1:0];
               CSR_HOLE_TICKS_FAST: cfg.hole_ticks_fast = csr_wdata[TICK_BITS-1:0];
               CSR_HOLE_TICKS_SLOW: cfg.hole_ticks_slow = csr_wdata[TICK_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            it.op = req_tuser;
            it.height = req_tdata[HEIGHT_BITS-1:0];
            it.slow_mode = req_tdata[HEIGHT_BITS];
            classify_step(it, done, want);
            if (done)
               outcome_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.hole_found = rsp_tdata[0];
            got.outcome = outcome_type'(rsp_tdata[2:1]);
            n_results++;
            if (got.hole_found)
               n_holes++;
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected result hole_found=%0d outcome=%0d", $time,
                        got.hole_found, got.outcome);
               n_fail++;
            end else begin
               want = outcome_q.pop_front();
               if (got.hole_found !== want.hole_found || got.outcome !== want.outcome) begin
                  $display("%0t: mismatch expected hole_found=%0d outcome=%0d,",
                           $time, want.hole_found, want.outcome,
                           " got hole_found=%0d outcome=%0d",
                           got.hole_found, got.outcome);
                  n_fail++;
               end
            end
         end
      end
      pending <= outcome_q.size();
      fail_count <= n_fail;
      results_seen <= n_results;
      holes_seen <= n_holes;
   end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import phd_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HEIGHT_MAX = (1 << HEIGHT_BITS) - 1;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int results_seen;
   int holes_seen;
   int cycle_count = 0;
   int items_sent = 0;
   int settings_used = 0;
   int sender_idle_pct = 0;
   int recv_idle_pct = 0;
   int cur_thr = 0;
   int cur_depth = 0;

   puck_hole_detector i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   phd_outcome_check i_outcome_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending),
      .results_seen(results_seen),
      .holes_seen(holes_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run timed out after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int pick_height(int lo, int hi);
      if (lo < 0)
         lo = 0;
      if (hi > HEIGHT_MAX)
         hi = HEIGHT_MAX;
      if (lo > hi)
         return hi;
      return $urandom_range(hi, lo);
   endfunction

   function automatic logic pick_bit();
      return 1'($urandom_range(1));
   endfunction

   task automatic send_item(input logic [1:0] op, input int h, input logic slow);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= REQ_DATA_BITS'({slow, h[HEIGHT_BITS-1:0]});
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   task automatic load_settings(input int thr, input int depth, input int entry,
                                input int pf, input int ps, input int hf, input int hs);
      write_reg(CSR_PUCK_THRESHOLD, CSR_DATA_BITS'(($urandom_range(15) << HEIGHT_BITS) | thr));
      write_reg(CSR_HOLE_DEPTH, CSR_DATA_BITS'(($urandom_range(15) << HEIGHT_BITS) | depth));
      write_reg(CSR_ENTRY_TICKS, CSR_DATA_BITS'(entry));
      write_reg(CSR_PASS_TICKS_FAST, CSR_DATA_BITS'(pf));
      write_reg(CSR_PASS_TICKS_SLOW, CSR_DATA_BITS'(ps));
      write_reg(CSR_HOLE_TICKS_FAST, CSR_DATA_BITS'(hf));
      write_reg(CSR_HOLE_TICKS_SLOW, CSR_DATA_BITS'(hs));
      csr_we <= 1'b0;
      cur_thr = thr;
      cur_depth = depth;
      settings_used++;
   endtask

   task automatic some_ticks();
      int n;
      n = ($urandom_range(3) == 0) ? $urandom_range(14) : $urandom_range(2);
      repeat (n) send_item(OP_TICK, $urandom_range(HEIGHT_MAX), pick_bit());
   endtask

   task automatic entry_or_close_noise();
      int n;
      n = $urandom_range(2);
      repeat (n) begin
         if ($urandom_range(1) && cur_thr > 0)
            send_item(OP_SAMPLE, pick_height(0, cur_thr - 1), pick_bit());
         else
            some_ticks();
      end
   endtask

   task automatic run_puck();
      int peak;
      int lim;
      int h;
      int n;
      int r;
      send_item(OP_START, $urandom_range(HEIGHT_MAX), pick_bit());
      entry_or_close_noise();
      peak = pick_height(cur_thr, HEIGHT_MAX);
      send_item(OP_SAMPLE, peak, pick_bit());
      n = $urandom_range(3);
      repeat (n) begin
         if ($urandom_range(3) == 0) begin
            some_ticks();
         end else begin
            h = pick_height(peak - cur_depth + 1, HEIGHT_MAX);
            send_item(OP_SAMPLE, h, pick_bit());
            if (h > peak)
               peak = h;
         end
      end
      lim = peak - cur_depth;
      r = $urandom_range(9);
      if (r == 0 && lim >= 0) begin
         send_item(OP_SAMPLE, lim, pick_bit());
      end else if (r < 9 && lim > 0) begin
         send_item(OP_SAMPLE, pick_height(0, lim - 1), pick_bit());
         entry_or_close_noise();
         r = $urandom_range(9);
         if (r < 7 && cur_thr < HEIGHT_MAX)
            send_item(OP_SAMPLE, pick_height(cur_thr + 1, HEIGHT_MAX), pick_bit());
         else if (r < 9)
            send_item(OP_SAMPLE, cur_thr, pick_bit());
      end else begin
         some_ticks();
      end
   endtask

   initial begin
      int mode;
      int j;
      int stop;
      int r;
      sender_idle_pct = 11;
      recv_idle_pct = 71;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_settings(1000, 300, 3, 4, 6, 2, 3);
      send_item(OP_SAMPLE, HEIGHT_MAX, 1'b1);
      send_item(OP_TICK, 0, 1'b0);
      // entry stage runs out of ticks
      send_item(OP_START, 0, 1'b0);
      repeat (3) send_item(OP_TICK, 0, 1'b0);
      // sample exactly hole_depth below the peak
      send_item(OP_START, HEIGHT_MAX, 1'b1);
      send_item(OP_SAMPLE, 999, 1'b0);
      send_item(OP_SAMPLE, 1000, 1'b0);
      send_item(OP_SAMPLE, HEIGHT_MAX, 1'b0);
      send_item(OP_SAMPLE, HEIGHT_MAX - 300, 1'b0);
      // hole closes at exactly the threshold
      send_item(OP_START, 0, 1'b0);
      send_item(OP_SAMPLE, 1500, 1'b0);
      send_item(OP_SAMPLE, 1199, 1'b0);
      send_item(OP_SAMPLE, 0, 1'b0);
      send_item(OP_SAMPLE, 1000, 1'b0);
      // restart while busy, reserved op, then a complete hole
      send_item(OP_START, 0, 1'b1);
      send_item(OP_SAMPLE, 2000, 1'b0);
      send_item(OP_START, 0, 1'b0);
      send_item(OP_SAMPLE, 1200, 1'b0);
      send_item(OP_SAMPLE, 899, 1'b0);
      send_item(OP_RESERVED, HEIGHT_MAX, 1'b1);
      send_item(OP_SAMPLE, 1001, 1'b0);
      // track and close stages run out of ticks
      send_item(OP_START, 0, 1'b0);
      send_item(OP_SAMPLE, 1000, 1'b0);
      repeat (4) send_item(OP_TICK, 0, 1'b0);
      send_item(OP_START, 0, 1'b0);
      send_item(OP_SAMPLE, 1300, 1'b0);
      send_item(OP_SAMPLE, 0, 1'b0);
      repeat (2) send_item(OP_TICK, 0, 1'b0);

      for (mode = 0; mode < 3; mode++) begin
         sender_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 71 : 0;
         recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 11 : 0;
         for (j = 0; j < 3; j++) begin
            wait_quiet();
            case (mode * 3 + j)
               0: load_settings(0, 0, 1, 1, 1, 1, 1);
               1: load_settings(HEIGHT_MAX, HEIGHT_MAX, 65535, 65535, 65535, 65535, 65535);
               2: load_settings($urandom_range(3500, 500), $urandom_range(800, 50),
                                0, 0, 0, 0, 0);
               default: load_settings($urandom_range(3900, 100), $urandom_range(1200),
                                      $urandom_range(12, 1), $urandom_range(12, 1),
                                      $urandom_range(12, 1), $urandom_range(12, 1),
                                      $urandom_range(12, 1));
            endcase
            stop = items_sent + 100;
            while (items_sent < stop) begin
               r = $urandom_range(99);
               if (r < 2) begin
                  wait_quiet();
               end else if (r < 77) begin
                  run_puck();
               end else if (r < 90) begin
                  repeat ($urandom_range(4, 1))
                     send_item(2'($urandom_range(3)), $urandom_range(HEIGHT_MAX), pick_bit());
               end else begin
                  send_item(OP_START, $urandom_range(HEIGHT_MAX), pick_bit());
                  repeat ($urandom_range(5, 1))
                     send_item(2'($urandom_range(3, 1)), $urandom_range(HEIGHT_MAX),
                               pick_bit());
               end
            end
         end
      end

      wait_quiet();
      $display("Drove %0d transactions under %0d register settings and three idle mixes.",
               items_sent, settings_used);
      $display("Checked %0d results, %0d of them reporting a complete hole.",
               results_seen, holes_seen);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
